>>> sv/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AFE_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("afe assertion failed");

// Next-cycle implication, disabled during reset.
`define AFE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("afe assertion failed");

`endif

>>> sv/afe_pkg.sv
// Shared types, register codes and the microcode program of the envelope front end.
package afe_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd5;

  localparam logic [3:0]         GAIN_RST = 4'd4;
  localparam logic signed [15:0] B0_RST   = 16'sd15847;
  localparam logic signed [15:0] B1_RST   = -16'sd31693;
  localparam logic signed [15:0] B2_RST   = 16'sd15847;
  localparam logic signed [15:0] A1_RST   = -16'sd31677;
  localparam logic signed [15:0] A2_RST   = 16'sd15319;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_MGAIN = 4'd1;
  localparam step_t S_CLIP  = 4'd2;
  localparam step_t S_MB0   = 4'd3;
  localparam step_t S_Y     = 4'd4;
  localparam step_t S_MB1   = 4'd5;
  localparam step_t S_MA1   = 4'd6;
  localparam step_t S_MB2   = 4'd7;
  localparam step_t S_MA2   = 4'd8;
  localparam step_t S_ACC2  = 4'd9;
  localparam step_t S_STAT  = 4'd10;
  localparam step_t S_DIV   = 4'd11;
  localparam step_t S_OUT   = 4'd12;

  typedef enum logic [1:0] {MA_XS, MA_X, MA_Y} mul_a_t;
  typedef enum logic [2:0] {MB_GAIN, MB_B0, MB_B1, MB_B2, MB_A1, MB_A2} mul_b_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_P_D2, ACC_SUB_SH, ACC_LOAD_P} acc_op_t;
  typedef enum logic [2:0] {W_NONE, W_X, W_Y, W_D1, W_D2} wr_t;
  typedef enum logic [2:0] {C_NEXT, C_WAIT_IN, C_CHUNK, C_WAIT_OUT, C_GOTO} cond_t;

  typedef struct packed {
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    acc_op_t acc_op;
    wr_t     wr;
    logic    load_in;
    logic    stats_en;
    logic    div_en;
    logic    load_out;
    cond_t   cond;
    step_t   target;
  } ucode_t;

  typedef struct packed {
    logic close_now;
  } stat_t;

  localparam ucode_t UC_NOP = '{
    mul_a: MA_XS, mul_b: MB_GAIN, acc_op: ACC_HOLD, wr: W_NONE,
    load_in: 1'b0, stats_en: 1'b0, div_en: 1'b0, load_out: 1'b0,
    cond: C_NEXT, target: S_IDLE
  };

  // Program ROM: products go through the shared multiplier, one per step.
  function automatic ucode_t ucode(input step_t s);
    ucode_t w;
    w = UC_NOP;
    case (s)
      S_IDLE: begin
        w.load_in = 1'b1;
        w.cond    = C_WAIT_IN;
      end
      S_MGAIN: begin
        w.mul_a = MA_XS;
        w.mul_b = MB_GAIN;
      end
      S_CLIP: w.wr = W_X;
      S_MB0: begin
        w.mul_a = MA_X;
        w.mul_b = MB_B0;
      end
      S_Y: w.wr = W_Y;
      S_MB1: begin
        w.mul_a = MA_X;
        w.mul_b = MB_B1;
      end
      S_MA1: begin
        w.mul_a  = MA_Y;
        w.mul_b  = MB_A1;
        w.acc_op = ACC_P_D2;
      end
      S_MB2: begin
        w.mul_a  = MA_X;
        w.mul_b  = MB_B2;
        w.acc_op = ACC_SUB_SH;
      end
      S_MA2: begin
        w.mul_a  = MA_Y;
        w.mul_b  = MB_A2;
        w.acc_op = ACC_LOAD_P;
        w.wr     = W_D1;
      end
      S_ACC2: w.acc_op = ACC_SUB_SH;
      S_STAT: begin
        w.wr       = W_D2;
        w.stats_en = 1'b1;
        w.cond     = C_CHUNK;
        w.target   = S_OUT;
      end
      S_DIV: w.div_en = 1'b1;
      S_OUT: begin
        w.load_out = 1'b1;
        w.cond     = C_WAIT_OUT;
        w.target   = S_IDLE;
      end
      default: begin
        w.cond   = C_GOTO;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> sv/afe_in_if.sv
// Input channel: one raw microphone word per request.
interface afe_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] raw_word;

  modport source (output valid, output raw_word, input ready);
  modport sink (input valid, input raw_word, output ready);
endinterface

>>> sv/afe_out_if.sv
// Output channel: one filtered sample with its statistics per request.
interface afe_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] filtered_sample;
  logic [13:0]       write_index;
  logic [6:0]        running_max;
  logic signed [7:0] running_min;
  logic              chunk_done;
  logic [7:0]        envelope_avg;

  modport source (output valid, output filtered_sample, output write_index,
                  output running_max, output running_min, output chunk_done,
                  output envelope_avg, input ready);
  modport sink (input valid, input filtered_sample, input write_index,
                input running_max, input running_min, input chunk_done,
                input envelope_avg, output ready);
endinterface

>>> sv/afe_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
module afe_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_free,
  input  afe_pkg::stat_t  status,
  output logic            in_ready,
  output afe_pkg::ucode_t ctl
);

  afe_pkg::step_t  step;
  afe_pkg::step_t  step_next;
  afe_pkg::ucode_t word;

  assign word     = afe_pkg::ucode(step);
  assign in_ready = word.load_in;

  always_comb begin
    ctl          = word;
    ctl.load_in  = word.load_in & in_valid;
    ctl.load_out = word.load_out & out_free;
  end

  always_comb begin
    case (word.cond)
      afe_pkg::C_NEXT:     step_next = afe_pkg::step_t'(step + 1'b1);
      afe_pkg::C_WAIT_IN:  step_next = in_valid ? afe_pkg::step_t'(step + 1'b1) : step;
      afe_pkg::C_CHUNK:    step_next = status.close_now ? afe_pkg::step_t'(step + 1'b1)
                                                        : word.target;
      afe_pkg::C_WAIT_OUT: step_next = out_free ? word.target : step;
      afe_pkg::C_GOTO:     step_next = word.target;
      default:             step_next = afe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= afe_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> sv/afe_dp.sv
// Filter datapath: config registers, shared multiplier, accumulator and biquad state.
module afe_dp #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [afe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afe_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [31:0]                 raw_word,
  input  afe_pkg::ucode_t                    ctl,
  output logic signed [7:0]                  q
);

  localparam int PW = 49;
  localparam int AW = 50;
  localparam logic signed [31:0] LIM_HI = 32'sd127 * (32'sd1 <<< COEF_FRAC_BITS);
  localparam logic signed [31:0] LIM_LO = -32'sd128 * (32'sd1 <<< COEF_FRAC_BITS);

  logic [3:0]               gain;
  logic signed [15:0]       coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [24:0]       xs;
  logic signed [7:0]        x;
  logic signed [31:0]       y;
  logic signed [31:0]       delay_one, delay_two;
  logic signed [PW-1:0]     p;
  logic signed [AW-1:0]     acc;
  logic signed [31:0]       a_op;
  logic signed [16:0]       b_op;
  logic signed [7:0]        x_clip;
  logic signed [AW-1:0]     y_sum;
  logic [31:0]              y_mag;

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    if (v[AW-1:31] == '0 || v[AW-1:31] == '1) begin
      return v[31:0];
    end
    return v[AW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      gain    <= afe_pkg::GAIN_RST;
      coef_b0 <= afe_pkg::B0_RST;
      coef_b1 <= afe_pkg::B1_RST;
      coef_b2 <= afe_pkg::B2_RST;
      coef_a1 <= afe_pkg::A1_RST;
      coef_a2 <= afe_pkg::A2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        afe_pkg::REG_GAIN: gain    <= cfg_data[3:0];
        afe_pkg::REG_B0:   coef_b0 <= cfg_data;
        afe_pkg::REG_B1:   coef_b1 <= cfg_data;
        afe_pkg::REG_B2:   coef_b2 <= cfg_data;
        afe_pkg::REG_A1:   coef_a1 <= cfg_data;
        afe_pkg::REG_A2:   coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctl.mul_a)
      afe_pkg::MA_XS: a_op = 32'(xs);
      afe_pkg::MA_X:  a_op = 32'(x);
      afe_pkg::MA_Y:  a_op = y;
      default:        a_op = y;
    endcase
    case (ctl.mul_b)
      afe_pkg::MB_GAIN: b_op = {13'd0, gain};
      afe_pkg::MB_B0:   b_op = 17'(coef_b0);
      afe_pkg::MB_B1:   b_op = 17'(coef_b1);
      afe_pkg::MB_B2:   b_op = 17'(coef_b2);
      afe_pkg::MB_A1:   b_op = 17'(coef_a1);
      afe_pkg::MB_A2:   b_op = 17'(coef_a2);
      default:          b_op = '0;
    endcase
  end

  always_comb begin
    if (p > 49'sd127) begin
      x_clip = 8'sd127;
    end else if (p < -49'sd128) begin
      x_clip = -8'sd128;
    end else begin
      x_clip = p[7:0];
    end
  end

  assign y_sum = AW'(p) + AW'(delay_one);

  // output quantizer: clamp, then truncate toward zero
  always_comb begin
    y_mag = -y;
    if (y > LIM_HI) begin
      q = 8'sd127;
    end else if (y < LIM_LO) begin
      q = -8'sd128;
    end else if (!y[31]) begin
      q = 8'(y >>> COEF_FRAC_BITS);
    end else begin
      q = -(8'(y_mag >> COEF_FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    p <= a_op * b_op;
    if (ctl.load_in) begin
      xs <= raw_word[31:7];
    end
    case (ctl.acc_op)
      afe_pkg::ACC_P_D2:   acc <= AW'(p) + AW'(delay_two);
      afe_pkg::ACC_SUB_SH: acc <= acc - AW'(p >>> COEF_FRAC_BITS);
      afe_pkg::ACC_LOAD_P: acc <= AW'(p);
      default: ;
    endcase
    if (ctl.wr == afe_pkg::W_X) begin
      x <= x_clip;
    end
    if (ctl.wr == afe_pkg::W_Y) begin
      y <= sat32(y_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      if (ctl.wr == afe_pkg::W_D1) begin
        delay_one <= sat32(acc);
      end
      if (ctl.wr == afe_pkg::W_D2) begin
        delay_two <= sat32(acc);
      end
    end
  end

endmodule

>>> sv/afe_stats.sv
// Sample statistics: running peaks, ring slot, chunk sum and the reciprocal-multiply average.
module afe_stats #(
  parameter int CHUNK_LEN  = 128,
  parameter int RING_DEPTH = 16384
) (
  input  logic              clk,
  input  logic              rst,
  input  afe_pkg::ucode_t   ctl,
  input  logic signed [7:0] q,
  output afe_pkg::stat_t    status,
  output logic [6:0]        peak_high,
  output logic signed [7:0] peak_low,
  output logic [13:0]       write_index,
  output logic              done,
  output logic [7:0]        quo
);

  localparam int FW     = $clog2(CHUNK_LEN);
  localparam int SW     = $clog2(128 * CHUNK_LEN + 1);
  localparam int RW     = $clog2(RING_DEPTH);
  localparam int MW     = SW + 2;
  localparam int DIV_SH = SW + FW;
  // ceil(2^DIV_SH / CHUNK_LEN) gives the exact floor quotient for any SW-bit sum
  localparam longint DIV_M = ((longint'(1) <<< DIV_SH) + CHUNK_LEN - 1) / CHUNK_LEN;
  localparam logic [MW-1:0] DIV_RECIP = MW'(DIV_M);

  logic [FW-1:0]    chunk_fill;
  logic [SW-1:0]    magnitude_sum;
  logic [SW-1:0]    sum_next;
  logic [SW-1:0]    rem;
  logic [SW+MW-1:0] prod;
  logic [RW-1:0]    ring_position;
  logic [RW+13:0]   ring_ext;
  logic [7:0]       mag;

  assign mag      = q[7] ? (~q + 8'd1) : q;
  assign sum_next = SW'(magnitude_sum + SW'(mag));
  assign prod     = rem * DIV_RECIP;
  assign ring_ext = {14'd0, ring_position};
  assign write_index = ring_ext[13:0];

  assign status.close_now = (chunk_fill == FW'(CHUNK_LEN - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_high     <= '0;
      peak_low      <= '0;
      chunk_fill    <= '0;
      magnitude_sum <= '0;
      ring_position <= '0;
      done          <= 1'b0;
      quo           <= '0;
    end else begin
      if (ctl.stats_en) begin
        if (q > $signed({1'b0, peak_high})) begin
          peak_high <= q[6:0];
        end
        if (q < peak_low) begin
          peak_low <= q;
        end
        quo  <= '0;
        done <= status.close_now;
        if (status.close_now) begin
          chunk_fill    <= '0;
          magnitude_sum <= '0;
          rem           <= sum_next;
        end else begin
          chunk_fill    <= FW'(chunk_fill + 1'b1);
          magnitude_sum <= sum_next;
        end
      end
      // chunk average: closed sum times the reciprocal of the chunk length
      if (ctl.div_en) begin
        quo <= prod[DIV_SH +: 8];
      end
      if (ctl.load_out) begin
        if (ring_position == RW'(RING_DEPTH - 1)) begin
          ring_position <= '0;
        end else begin
          ring_position <= RW'(ring_position + 1'b1);
        end
      end
    end
  end

endmodule

>>> sv/audio_frontend_envelope_core.sv
// One sample at a time: the next sample is taken only after the last result is loaded
// into the result register, which waits while an earlier result is still held; the microcode
// program runs the five filter products and the gain through one shared multiplier,
// and the chunk average takes one extra step for its reciprocal multiply.
// Reset (rst, synchronous): filter state, peaks, chunk and ring counters clear,
// configuration returns to its default values, no result is pending.
module audio_frontend_envelope_core #(
  parameter int CHUNK_LEN      = 128,
  parameter int RING_DEPTH     = 16384,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [afe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afe_pkg::CFG_DATA_W-1:0] cfg_data,
  afe_in_if.sink                         sample_in,
  afe_out_if.source                      result_out
);

  afe_pkg::ucode_t   ctl;
  afe_pkg::stat_t    status;
  logic              out_valid;
  logic              out_free;
  logic signed [7:0] q;
  logic [6:0]        peak_high;
  logic signed [7:0] peak_low;
  logic [13:0]       write_index;
  logic              done;
  logic [7:0]        quo;

  assign out_free = !out_valid || result_out.ready;

  afe_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .out_free (out_free),
    .status   (status),
    .in_ready (sample_in.ready),
    .ctl      (ctl)
  );

  afe_dp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .raw_word  (sample_in.raw_word),
    .ctl       (ctl),
    .q         (q)
  );

  afe_stats #(
    .CHUNK_LEN  (CHUNK_LEN),
    .RING_DEPTH (RING_DEPTH)
  ) u_stats (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .q           (q),
    .status      (status),
    .peak_high   (peak_high),
    .peak_low    (peak_low),
    .write_index (write_index),
    .done        (done),
    .quo         (quo)
  );

  // result register parts the sequencer from the downstream side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      result_out.filtered_sample <= q;
      result_out.write_index     <= write_index;
      result_out.running_max     <= peak_high;
      result_out.running_min     <= peak_low;
      result_out.chunk_done      <= done;
      result_out.envelope_avg    <= quo;
    end
  end

  assign result_out.valid = out_valid;

endmodule

>>> sv/afe_checker.sv
// Port-level checker for the envelope front end and its bind to the top level.
`include "assert_macros.svh"

module afe_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] running_min,
  input logic              chunk_done,
  input logic [7:0]        envelope_avg
);

  // a pending result is not dropped
  `AFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // one sample at a time: no new request right after one is taken
  `AFE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `AFE_ASSERT(a_min_nonpos, out_valid, running_min[7] || running_min == 8'sd0)
  `AFE_ASSERT(a_avg_only_done, out_valid && !chunk_done, envelope_avg == 8'd0)

endmodule

bind audio_frontend_envelope_core afe_checker u_afe_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample_in.valid),
  .in_ready     (sample_in.ready),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .running_min  (result_out.running_min),
  .chunk_done   (result_out.chunk_done),
  .envelope_avg (result_out.envelope_avg)
);
